[rtl/lamp_fade_dimmer_controller_top_macros.svh]
// Assertion helpers shared by the top level.
`ifndef LAMP_FADE_DIMMER_CONTROLLER_TOP_MACROS_SVH
`define LAMP_FADE_DIMMER_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LFDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LFDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lfdc_pkg.sv]
`timescale 1ns / 1ps

package lfdc_pkg;

  localparam int LEVEL_W    = 7;
  localparam int MODE_W     = 3;
  localparam int OP_W       = 3;
  localparam int STEP_W     = 16;
  localparam int TICK_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = LEVEL_W + TICK_W;
  localparam int QUO_W      = LEVEL_W;
  localparam int DIV_CNT_W  = 3;

  localparam logic [STEP_W-1:0]  RST_FADE_STEP    = 16'd3;
  localparam logic [TICK_W-1:0]  RST_IDLE_TIMEOUT = 24'd900000;
  localparam logic [TICK_W-1:0]  RST_AUTO_FADE    = 24'd60000;
  localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL    = 7'd5;
  localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL    = 7'd100;
  localparam logic [LEVEL_W-1:0] RST_DEFAULT      = 7'd50;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_FADE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT      = 3'd5;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF      = 3'd0,
    MODE_FADE_IN  = 3'd1,
    MODE_ON       = 3'd2,
    MODE_FADE_OUT = 3'd3,
    MODE_DIMMING  = 3'd4,
    MODE_AUTO     = 3'd5
  } mode_e;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_PRESS   = 3'd1,
    OP_CLICK   = 3'd2,
    OP_HOLD    = 3'd3,
    OP_RELEASE = 3'd4,
    OP_WAKE    = 3'd5
  } opcode_e;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LATCH,
    DP_EVENT,
    DP_ON_PHASE,
    DP_AUTO_PHASE,
    DP_MUL,
    DP_DIV,
    DP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic div_needed;
    logic div_last;
  } dp_status_t;

endpackage

[rtl/lfdc_ctrl.sv]
`timescale 1ns / 1ps

module lfdc_ctrl
  import lfdc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVENT,
    S_ON_CHK,
    S_AUTO_CHK,
    S_MUL,
    S_DIV,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  // The output register takes a new result once it is empty or being drained.
  assign load = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = DP_NOP;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LATCH;
          state_d  = S_EVENT;
        end
      end
      S_EVENT: begin
        cmd_o.op = DP_EVENT;
        state_d  = status_i.is_tick ? S_ON_CHK : S_RESULT;
      end
      S_ON_CHK: begin
        cmd_o.op = DP_ON_PHASE;
        state_d  = S_AUTO_CHK;
      end
      S_AUTO_CHK: begin
        cmd_o.op = DP_AUTO_PHASE;
        state_d  = status_i.div_needed ? S_MUL : S_RESULT;
      end
      S_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = DP_DIV;
        if (status_i.div_last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (load) begin
          cmd_o.op    = DP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/lfdc_datapath.sv]
`timescale 1ns / 1ps

module lfdc_datapath
  import lfdc_pkg::*;
#(
  parameter int TIMER_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic                  touch_active_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic [LEVEL_W-1:0]    level_o,
  output logic [MODE_W-1:0]     lamp_mode_o,
  output logic                  level_adjusted_o
);

  localparam int CmpW = (TIMER_BITS > TICK_W) ? TIMER_BITS : TICK_W;

  // Configuration registers.
  logic [STEP_W-1:0]  fade_step_q;
  logic [TICK_W-1:0]  idle_to_q;
  logic [TICK_W-1:0]  auto_fade_q;
  logic [LEVEL_W-1:0] min_q;
  logic [LEVEL_W-1:0] max_q;
  logic [LEVEL_W-1:0] default_q;

  // Lamp state.
  mode_e                 mode_q, mode_d;
  logic [LEVEL_W-1:0]    cur_q, cur_d;
  logic [LEVEL_W-1:0]    tgt_q, tgt_d;
  logic [LEVEL_W-1:0]    kept_q, kept_d;
  logic                  ramp_q, ramp_d;
  logic                  cancel_q, cancel_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [TIMER_BITS-1:0] idle_q, idle_d;
  logic [TIMER_BITS-1:0] auto_q, auto_d;
  logic [LEVEL_W-1:0]    astart_q, astart_d;

  // Event latch and working registers.
  logic [OP_W-1:0]      op_q, op_d;
  logic                 touch_q, touch_d;
  logic                 adj_q, adj_d;
  logic [TICK_W-1:0]    rem_q, rem_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  // Output register.
  logic [LEVEL_W-1:0] out_level_q, out_level_d;
  logic [MODE_W-1:0]  out_mode_q, out_mode_d;
  logic               out_adj_q, out_adj_d;

  logic [LEVEL_W-1:0]    fade_tgt;
  logic [LEVEL_W-1:0]    cur_inc;
  logic [LEVEL_W-1:0]    cur_dec;
  logic [LEVEL_W-1:0]    dim_level;
  logic [STEP_W-1:0]     step_inc;
  logic [TIMER_BITS-1:0] idle_inc;
  logic [TIMER_BITS-1:0] auto_inc;
  logic [CmpW-1:0]       auto_inc_ext;
  logic [CmpW-1:0]       auto_fade_ext;
  logic [CmpW-1:0]       rem_diff;
  logic                  auto_done;
  logic [PROD_W-1:0]     div_shift;
  logic                  div_bit;
  logic [QUO_W-1:0]      quo_next;

  assign fade_tgt      = (kept_q >= min_q) ? kept_q : default_q;
  assign cur_inc       = cur_q + 7'd1;
  assign cur_dec       = cur_q - 7'd1;
  assign step_inc      = step_q + 16'd1;
  assign idle_inc      = idle_q + TIMER_BITS'(1);
  assign auto_inc      = auto_q + TIMER_BITS'(1);
  assign auto_inc_ext  = CmpW'(auto_inc);
  assign auto_fade_ext = CmpW'(auto_fade_q);
  assign rem_diff      = auto_fade_ext - auto_inc_ext;
  assign auto_done     = (auto_inc_ext >= auto_fade_ext);

  always_comb begin
    if (ramp_q) begin
      dim_level = (cur_q < max_q) ? cur_inc : cur_q;
    end else begin
      dim_level = (cur_q > min_q) ? cur_dec : cur_q;
    end
  end

  // One quotient bit per step: the quotient is below auto_start_level,
  // so it always fits in QUO_W bits.
  assign div_shift = PROD_W'(auto_fade_q) << div_cnt_q;
  assign div_bit   = (prod_q >= div_shift);
  assign quo_next  = {quo_q[QUO_W-2:0], div_bit};

  assign status_o.is_tick    = (op_q == OP_TICK);
  assign status_o.div_needed = (mode_q == MODE_AUTO) && !auto_done;
  assign status_o.div_last   = (div_cnt_q == '0);

  always_comb begin
    mode_d      = mode_q;
    cur_d       = cur_q;
    tgt_d       = tgt_q;
    kept_d      = kept_q;
    ramp_d      = ramp_q;
    cancel_d    = cancel_q;
    step_d      = step_q;
    idle_d      = idle_q;
    auto_d      = auto_q;
    astart_d    = astart_q;
    op_d        = op_q;
    touch_d     = touch_q;
    adj_d       = adj_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    quo_d       = quo_q;
    div_cnt_d   = div_cnt_q;
    out_level_d = out_level_q;
    out_mode_d  = out_mode_q;
    out_adj_d   = out_adj_q;

    case (cmd_i.op)
      DP_LATCH: begin
        op_d    = opcode_i;
        touch_d = touch_active_i;
        adj_d   = 1'b0;
      end
      DP_EVENT: begin
        case (op_q)
          OP_TICK: begin
            // Manual fade stage of a tick.
            if ((mode_q == MODE_FADE_IN) || (mode_q == MODE_FADE_OUT)) begin
              if (step_inc >= fade_step_q) begin
                step_d = '0;
                if (cur_q < tgt_q) begin
                  cur_d = cur_inc;
                  if (cur_inc >= tgt_q) begin
                    mode_d = MODE_ON;
                    idle_d = '0;
                  end
                end else if (cur_q > tgt_q) begin
                  cur_d = cur_dec;
                  if (cur_dec == '0) begin
                    mode_d = MODE_OFF;
                  end
                end
              end else begin
                step_d = step_inc;
              end
            end
          end
          OP_PRESS: begin
            if (mode_q == MODE_AUTO) begin
              tgt_d    = fade_tgt;
              mode_d   = MODE_FADE_IN;
              step_d   = '0;
              idle_d   = '0;
              cancel_d = 1'b1;
            end
          end
          OP_CLICK: begin
            if (cancel_q) begin
              cancel_d = 1'b0;
            end else if (mode_q == MODE_OFF) begin
              tgt_d  = fade_tgt;
              mode_d = MODE_FADE_IN;
              step_d = '0;
              idle_d = '0;
            end else if ((mode_q == MODE_ON) || (mode_q == MODE_FADE_IN)) begin
              tgt_d  = '0;
              mode_d = MODE_FADE_OUT;
              step_d = '0;
            end
          end
          OP_HOLD: begin
            if ((mode_q == MODE_ON) || (mode_q == MODE_DIMMING)) begin
              mode_d = MODE_DIMMING;
              idle_d = '0;
              cur_d  = dim_level;
              kept_d = dim_level;
              adj_d  = 1'b1;
            end
          end
          OP_RELEASE: begin
            ramp_d = !ramp_q;
            if (mode_q == MODE_DIMMING) begin
              mode_d = MODE_ON;
              idle_d = '0;
            end
          end
          OP_WAKE: begin
            cancel_d = 1'b0;
            if (touch_q) begin
              tgt_d  = fade_tgt;
              mode_d = MODE_FADE_IN;
              step_d = '0;
              idle_d = '0;
            end
          end
          default: begin
          end
        endcase
      end
      DP_ON_PHASE: begin
        if (mode_q == MODE_ON) begin
          idle_d = idle_inc;
          if (CmpW'(idle_inc) >= CmpW'(idle_to_q)) begin
            mode_d   = MODE_AUTO;
            auto_d   = '0;
            astart_d = cur_q;
          end
        end
      end
      DP_AUTO_PHASE: begin
        if (mode_q == MODE_AUTO) begin
          auto_d = auto_inc;
          if (auto_done) begin
            cur_d  = '0;
            mode_d = MODE_OFF;
          end else begin
            rem_d = rem_diff[TICK_W-1:0];
          end
        end
      end
      DP_MUL: begin
        prod_d    = PROD_W'(astart_q) * PROD_W'(rem_q);
        quo_d     = '0;
        div_cnt_d = DIV_CNT_W'(QUO_W - 1);
      end
      DP_DIV: begin
        if (div_bit) begin
          prod_d = prod_q - div_shift;
        end
        quo_d     = quo_next;
        div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
        if (div_cnt_q == '0) begin
          cur_d = quo_next;
        end
      end
      DP_LOAD_OUT: begin
        out_level_d = cur_q;
        out_mode_d  = mode_q;
        out_adj_d   = adj_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_step_q <= RST_FADE_STEP;
      idle_to_q   <= RST_IDLE_TIMEOUT;
      auto_fade_q <= RST_AUTO_FADE;
      min_q       <= RST_MIN_LEVEL;
      max_q       <= RST_MAX_LEVEL;
      default_q   <= RST_DEFAULT;
      mode_q      <= MODE_OFF;
      cur_q       <= '0;
      tgt_q       <= '0;
      kept_q      <= RST_DEFAULT;
      ramp_q      <= 1'b1;
      cancel_q    <= 1'b0;
      step_q      <= '0;
      idle_q      <= '0;
      auto_q      <= '0;
      astart_q    <= '0;
      op_q        <= '0;
      touch_q     <= 1'b0;
      adj_q       <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FADE_STEP:    fade_step_q <= cfg_data_i[STEP_W-1:0];
          REG_IDLE_TIMEOUT: idle_to_q   <= cfg_data_i[TICK_W-1:0];
          REG_AUTO_FADE:    auto_fade_q <= cfg_data_i[TICK_W-1:0];
          REG_MIN_LEVEL:    min_q       <= cfg_data_i[LEVEL_W-1:0];
          REG_MAX_LEVEL:    max_q       <= cfg_data_i[LEVEL_W-1:0];
          REG_DEFAULT:      default_q   <= cfg_data_i[LEVEL_W-1:0];
          default: begin
          end
        endcase
      end
      mode_q    <= mode_d;
      cur_q     <= cur_d;
      tgt_q     <= tgt_d;
      kept_q    <= kept_d;
      ramp_q    <= ramp_d;
      cancel_q  <= cancel_d;
      step_q    <= step_d;
      idle_q    <= idle_d;
      auto_q    <= auto_d;
      astart_q  <= astart_d;
      op_q      <= op_d;
      touch_q   <= touch_d;
      adj_q     <= adj_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    prod_q      <= prod_d;
    quo_q       <= quo_d;
    out_level_q <= out_level_d;
    out_mode_q  <= out_mode_d;
    out_adj_q   <= out_adj_d;
  end

  assign level_o          = out_level_q;
  assign lamp_mode_o      = out_mode_q;
  assign level_adjusted_o = out_adj_q;

endmodule

[rtl/lamp_fade_dimmer_controller_top.sv]
// Lamp fade and dimmer controller.
// Input channel: in_valid_i / in_stall_o with in_opcode_i and in_touch_active_i.
// One event is taken per transaction; every event yields exactly one result.
// Output channel: out_valid_o / out_stall_i with out_level_o, out_lamp_mode_o
// and out_level_adjusted_o, held in an output register.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high. Write registers only while the block is idle.
// Non-tick events pass through the latch, event and result states; a tick adds
// the on-phase and auto-phase checks, and during the auto fade a multiply and a
// 7-step restoring divider produce the new level. The next event is accepted in
// the cycle after the result enters the output register, so a new event can be
// taken while a result is still stalled there.
// If the receiver stalls while the output register is full, the controller
// holds its finished result and in_stall_o stays high until it moves.
// Reset puts the lamp off at level 0, the saved level at 50, dims upward,
// and loads the register defaults.
`timescale 1ns / 1ps
`include "lamp_fade_dimmer_controller_top_macros.svh"

module lamp_fade_dimmer_controller_top
  import lfdc_pkg::*;
#(
  parameter int TIMER_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       in_opcode_i,
  input  logic                  in_touch_active_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_W-1:0]    out_level_o,
  output logic [MODE_W-1:0]     out_lamp_mode_o,
  output logic                  out_level_adjusted_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  lfdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lfdc_datapath #(
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (in_opcode_i),
    .touch_active_i   (in_touch_active_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .level_o          (out_level_o),
    .lamp_mode_o      (out_lamp_mode_o),
    .level_adjusted_o (out_level_adjusted_o)
  );

  // An accepted event keeps the input side busy while it is worked on.
  `LFDC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted event did not make the block busy")
  // The lamp is never reported off with a nonzero level.
  `LFDC_ASSERT_NOW(a_off_is_dark, out_valid_o && (out_lamp_mode_o == MODE_OFF), out_level_o == '0, "lamp off with nonzero level")
  // An accepted hold step always leaves the lamp dimming.
  `LFDC_ASSERT_NOW(a_adjust_in_dimming, out_valid_o && out_level_adjusted_o, out_lamp_mode_o == MODE_DIMMING, "level adjusted outside dimming mode")

endmodule
